// ----- design/rac_pkg.sv -----
// Shared widths, types and pipeline constants for the RGBA alpha compositor.
`timescale 1ns / 1ps
package rac_pkg;

    localparam int CH_W       = 8;   // one colour or alpha channel
    localparam int K_W        = 16;  // blend weights and divisor
    localparam int PROD_W     = 24;  // channel times weight
    localparam int NUM_W      = 25;  // sum of two products
    localparam int LANES      = 3;   // red, green, blue
    localparam int QBITS      = 8;   // quotient bits, one per division stage
    localparam int NST        = 12;  // pipeline stages, input register to output register
    localparam int DIV_STAGES = 10;  // stages that carry the divisor

    localparam logic [CH_W-1:0] CHAN_MAX = 8'hFF;

    typedef logic [CH_W-1:0]   t_chan;
    typedef logic [K_W-1:0]    t_k;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [NUM_W-1:0]  t_num;
    typedef logic [NST-1:0]    t_en;
    typedef logic [DIV_STAGES-1:0][K_W-1:0] t_div_pipe;

endpackage

// ----- design/rac_in_if.sv -----
// Input channel: destination and source RGBA pixel with valid/ready.
`timescale 1ns / 1ps
interface rac_in_if;
    logic           valid;
    logic           ready;
    rac_pkg::t_chan dst_red;
    rac_pkg::t_chan dst_green;
    rac_pkg::t_chan dst_blue;
    rac_pkg::t_chan dst_alpha;
    rac_pkg::t_chan src_red;
    rac_pkg::t_chan src_green;
    rac_pkg::t_chan src_blue;
    rac_pkg::t_chan src_alpha;

    modport source (
        output valid, dst_red, dst_green, dst_blue, dst_alpha,
               src_red, src_green, src_blue, src_alpha,
        input  ready
    );
    modport sink (
        input  valid, dst_red, dst_green, dst_blue, dst_alpha,
               src_red, src_green, src_blue, src_alpha,
        output ready
    );
endinterface

// ----- design/rac_out_if.sv -----
// Output channel: composited RGBA pixel with valid/ready.
`timescale 1ns / 1ps
interface rac_out_if;
    logic           valid;
    logic           ready;
    rac_pkg::t_chan out_red;
    rac_pkg::t_chan out_green;
    rac_pkg::t_chan out_blue;
    rac_pkg::t_chan out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

// ----- design/rac_lane.sv -----
// One colour lane: weighted sum of two channels and a pipelined restoring divide.
`timescale 1ns / 1ps
module rac_lane (
    input  logic               i_clk,
    input  rac_pkg::t_en       i_en,
    input  rac_pkg::t_chan     i_d,
    input  rac_pkg::t_chan     i_s,
    input  rac_pkg::t_k        i_k1,
    input  rac_pkg::t_k        i_k2,
    input  rac_pkg::t_div_pipe i_div,
    output rac_pkg::t_chan     o_q,
    output logic               o_sat
);

    rac_pkg::t_prod r_p1;
    rac_pkg::t_prod r_p2;
    rac_pkg::t_num  r_rem [0:rac_pkg::QBITS-1];
    rac_pkg::t_chan r_q   [1:rac_pkg::QBITS];
    logic           r_sat [1:rac_pkg::QBITS];

    // Stage 1: both products.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_p1 <= rac_pkg::t_prod'(i_d) * rac_pkg::t_prod'(i_k1);
            r_p2 <= rac_pkg::t_prod'(i_s) * rac_pkg::t_prod'(i_k2);
        end
    end

    // Stage 2: numerator.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_rem[0] <= rac_pkg::t_num'(r_p1) + rac_pkg::t_num'(r_p2);
        end
    end

    // Stages 3..10: one quotient bit each, most significant first.
    for (genvar j = 1; j <= rac_pkg::QBITS; j++) begin : g_div
        localparam int B = rac_pkg::QBITS - j;
        rac_pkg::t_num  w_sub;
        logic           w_ge;
        rac_pkg::t_chan w_qin;
        logic           w_sat;

        assign w_sub = rac_pkg::t_num'(i_div[1+j]) << B;
        assign w_ge  = (r_rem[j-1] >= w_sub);

        if (j == 1) begin : g_first
            assign w_qin = '0;
            // quotient of 256 or more when numerator reaches divisor * 256
            assign w_sat = (r_rem[0] >= (rac_pkg::t_num'(i_div[2]) << rac_pkg::QBITS));
        end else begin : g_next
            assign w_qin = r_q[j-1];
            assign w_sat = r_sat[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en[2+j]) begin
                r_q[j]   <= {w_qin[rac_pkg::CH_W-2:0], w_ge};
                r_sat[j] <= w_sat;
            end
        end

        if (j < rac_pkg::QBITS) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en[2+j]) begin
                    r_rem[j] <= w_ge ? (r_rem[j-1] - w_sub) : r_rem[j-1];
                end
            end
        end
    end

    assign o_q   = r_q[rac_pkg::QBITS];
    assign o_sat = r_sat[rac_pkg::QBITS];

endmodule

// ----- design/rgba_alpha_composite.sv -----
// Top level of the RGBA "over" compositor: weight stage, three colour lanes, merge stage.
`timescale 1ns / 1ps
// Composites one 8-bit RGBA source pixel over one destination pixel per item.
// Weights k1 = (255 - src_alpha) * dst_alpha and k2 = src_alpha * 255 are
// shared by three identical colour lanes; each lane forms dst*k1 + src*k2 and
// divides it by max(max(dst_alpha, src_alpha) * 255, 1) in eight restoring
// steps, one quotient bit per pipeline stage. A quotient of 256 or more
// saturates to 255; output alpha is the larger of the two input alphas.
// Throughput is one item per cycle unless the output stalls. The item
// passes twelve registers on its way from acceptance to the output: the
// weight stage takes it at the accepting edge, then the product and sum
// stages, the eight divide stages and the merge register follow. Every stage
// has its own valid bit, so a stall on the output only holds stages that are
// full and bubbles collapse; the input stays ready while any stage is free.
// Both alphas zero gives a divisor of one and an all-zero pixel.
module rgba_alpha_composite (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rac_in_if.sink        i_in,
    rac_out_if.source     o_out
);

    localparam int NST   = rac_pkg::NST;
    localparam int LANES = rac_pkg::LANES;

    // ---------------------------------------------------------------
    // Stage flow control: a stage loads when empty or when it drains.
    // ---------------------------------------------------------------
    logic [NST-1:0] r_vld;
    logic [NST:0]   w_take;

    assign w_take[NST] = o_out.ready;
    for (genvar k = 0; k < NST; k++) begin : g_take
        assign w_take[k] = ~r_vld[k] | w_take[k+1];
    end

    assign i_in.ready = w_take[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_take[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_take[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: register the colours and form the shared weights.
    // ---------------------------------------------------------------
    rac_pkg::t_k    w_k1;
    rac_pkg::t_k    w_k2;
    rac_pkg::t_chan w_kmax;
    rac_pkg::t_k    w_div;

    assign w_k1   = rac_pkg::t_k'(rac_pkg::CHAN_MAX - i_in.src_alpha)
                  * rac_pkg::t_k'(i_in.dst_alpha);
    // times 255 as shift and subtract
    assign w_k2   = {i_in.src_alpha, 8'd0} - rac_pkg::t_k'(i_in.src_alpha);
    assign w_kmax = (i_in.dst_alpha > i_in.src_alpha) ? i_in.dst_alpha : i_in.src_alpha;
    // force a divisor of one when both alphas are zero
    assign w_div  = (w_kmax == '0) ? rac_pkg::t_k'(1)
                  : ({w_kmax, 8'd0} - rac_pkg::t_k'(w_kmax));

    rac_pkg::t_chan     r_dst [LANES];
    rac_pkg::t_chan     r_src [LANES];
    rac_pkg::t_k        r_k1;
    rac_pkg::t_k        r_k2;
    rac_pkg::t_div_pipe r_div;
    rac_pkg::t_chan     r_alpha [0:NST-2];

    always_ff @(posedge i_clk) begin
        if (w_take[0]) begin
            r_dst[0]   <= i_in.dst_red;
            r_dst[1]   <= i_in.dst_green;
            r_dst[2]   <= i_in.dst_blue;
            r_src[0]   <= i_in.src_red;
            r_src[1]   <= i_in.src_green;
            r_src[2]   <= i_in.src_blue;
            r_k1       <= w_k1;
            r_k2       <= w_k2;
            r_div[0]   <= w_div;
            r_alpha[0] <= w_kmax;
        end
    end

    // Carry divisor and alpha alongside the lane data.
    always_ff @(posedge i_clk) begin
        for (int k = 1; k < rac_pkg::DIV_STAGES; k++) begin
            if (w_take[k]) begin
                r_div[k] <= r_div[k-1];
            end
        end
        for (int k = 1; k < NST - 1; k++) begin
            if (w_take[k]) begin
                r_alpha[k] <= r_alpha[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Colour lanes.
    // ---------------------------------------------------------------
    rac_pkg::t_chan w_q   [LANES];
    logic           w_sat [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        rac_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_take[NST-1:0]),
            .i_d   (r_dst[l]),
            .i_s   (r_src[l]),
            .i_k1  (r_k1),
            .i_k2  (r_k2),
            .i_div (r_div),
            .o_q   (w_q[l]),
            .o_sat (w_sat[l])
        );
    end

    // ---------------------------------------------------------------
    // Merge stage: saturate each lane and join the pixel with its alpha.
    // ---------------------------------------------------------------
    rac_pkg::t_chan r_out [LANES];
    rac_pkg::t_chan r_out_alpha;

    always_ff @(posedge i_clk) begin
        if (w_take[NST-1]) begin
            for (int l = 0; l < LANES; l++) begin
                r_out[l] <= w_sat[l] ? rac_pkg::CHAN_MAX : w_q[l];
            end
            r_out_alpha <= r_alpha[NST-2];
        end
    end

    assign o_out.valid     = r_vld[NST-1];
    assign o_out.out_red   = r_out[0];
    assign o_out.out_green = r_out[1];
    assign o_out.out_blue  = r_out[2];
    assign o_out.out_alpha = r_out_alpha;

endmodule

// ----- tb/sv/rgba_alpha_composite_test.sv -----
// Testbench for the RGBA over compositor: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps
module rgba_alpha_composite_test;

    // One input item: destination pixel followed by source pixel.
    typedef struct packed {
        rac_pkg::t_chan dst_red;
        rac_pkg::t_chan dst_green;
        rac_pkg::t_chan dst_blue;
        rac_pkg::t_chan dst_alpha;
        rac_pkg::t_chan src_red;
        rac_pkg::t_chan src_green;
        rac_pkg::t_chan src_blue;
        rac_pkg::t_chan src_alpha;
    } t_pixel_pair;

    // One result item: the composited pixel.
    typedef struct packed {
        rac_pkg::t_chan red;
        rac_pkg::t_chan green;
        rac_pkg::t_chan blue;
        rac_pkg::t_chan alpha;
    } t_pixel_rgba;

    logic i_clk;
    logic i_rst_n;

    rac_in_if  in_ch ();
    rac_out_if out_ch ();

    rgba_alpha_composite DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Composited pixels still owed by the block, oldest first.
    t_pixel_rgba pending_pixels[$];

    int tx_idle_pct  = 0;   // chance in a hundred that the sender skips a cycle
    int rx_idle_pct  = 0;   // chance in a hundred that the receiver drops ready
    int rx_hold_len  = 0;   // request for a long receiver hold-off, in cycles
    int rx_hold_left = 0;
    int n_sent       = 0;
    int n_received   = 0;
    int n_errors     = 0;

    // Clock: 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Blend one colour lane: weighted sum over the divisor, saturated to 255.
    function automatic rac_pkg::t_chan blend_lane(rac_pkg::t_chan d, rac_pkg::t_chan s,
                                                  rac_pkg::t_k w_dst, rac_pkg::t_k w_src,
                                                  rac_pkg::t_k divisor);
        rac_pkg::t_num quo;
        quo = (rac_pkg::t_num'(d) * rac_pkg::t_num'(w_dst)
             + rac_pkg::t_num'(s) * rac_pkg::t_num'(w_src)) / rac_pkg::t_num'(divisor);
        return (quo > rac_pkg::t_num'(rac_pkg::CHAN_MAX)) ? rac_pkg::CHAN_MAX
                                                          : quo[rac_pkg::CH_W-1:0];
    endfunction

    // Composite the source pixel over the destination pixel.
    function automatic t_pixel_rgba composite_over(t_pixel_pair p);
        rac_pkg::t_k    w_dst;
        rac_pkg::t_k    w_src;
        rac_pkg::t_k    divisor;
        rac_pkg::t_chan a_max;
        t_pixel_rgba    r;
        w_dst   = (rac_pkg::t_k'(rac_pkg::CHAN_MAX) - rac_pkg::t_k'(p.src_alpha))
                * rac_pkg::t_k'(p.dst_alpha);
        w_src   = rac_pkg::t_k'(p.src_alpha) * rac_pkg::t_k'(rac_pkg::CHAN_MAX);
        a_max   = (p.dst_alpha > p.src_alpha) ? p.dst_alpha : p.src_alpha;
        divisor = rac_pkg::t_k'(a_max) * rac_pkg::t_k'(rac_pkg::CHAN_MAX);
        // Both alphas zero: force the divisor to one, every channel comes out zero.
        if (divisor == '0) begin
            divisor = rac_pkg::t_k'(1);
        end
        r.red   = blend_lane(p.dst_red,   p.src_red,   w_dst, w_src, divisor);
        r.green = blend_lane(p.dst_green, p.src_green, w_dst, w_src, divisor);
        r.blue  = blend_lane(p.dst_blue,  p.src_blue,  w_dst, w_src, divisor);
        r.alpha = a_max;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random ready, plus a long hold-off counted here on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_len != 0) begin
            rx_hold_left = rx_hold_len;
            rx_hold_len  = 0;
        end
        if (rx_hold_left != 0) begin
            out_ch.ready <= 1'b0;
            rx_hold_left  = rx_hold_left - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: queue a prediction for each accepted input item and
    // check each accepted result against the oldest one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel_rgba got;
        t_pixel_rgba want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.out_alpha};
                n_received++;
                if (pending_pixels.size() == 0) begin
                    $display("%0t: result with no pixel pending, got r=%0d g=%0d b=%0d a=%0d",
                             $time, got.red, got.green, got.blue, got.alpha);
                    n_errors++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (got !== want) begin
                        $display("%0t: pixel mismatch, expected r=%0d g=%0d b=%0d a=%0d",
                                 $time, want.red, want.green, want.blue, want.alpha);
                        $display("%0t:                 actual r=%0d g=%0d b=%0d a=%0d",
                                 $time, got.red, got.green, got.blue, got.alpha);
                        n_errors++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                pending_pixels.push_back(composite_over('{
                    in_ch.dst_red, in_ch.dst_green, in_ch.dst_blue, in_ch.dst_alpha,
                    in_ch.src_red, in_ch.src_green, in_ch.src_blue, in_ch.src_alpha}));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one item, idling at random first; return at the edge that accepts it.
    task automatic send_pixel(input t_pixel_pair p);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.dst_red   <= p.dst_red;
        in_ch.dst_green <= p.dst_green;
        in_ch.dst_blue  <= p.dst_blue;
        in_ch.dst_alpha <= p.dst_alpha;
        in_ch.src_red   <= p.src_red;
        in_ch.src_green <= p.src_green;
        in_ch.src_blue  <= p.src_blue;
        in_ch.src_alpha <= p.src_alpha;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        n_sent++;
    endtask

    // Drop valid and hold until every accepted item has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (n_received < n_sent) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_pixel_pair make_pair(rac_pkg::t_chan dr, rac_pkg::t_chan dg,
                                              rac_pkg::t_chan db, rac_pkg::t_chan da,
                                              rac_pkg::t_chan sr, rac_pkg::t_chan sg,
                                              rac_pkg::t_chan sb, rac_pkg::t_chan sa);
        return '{dr, dg, db, da, sr, sg, sb, sa};
    endfunction

    // Pick a colour value, leaning on the extremes.
    function automatic rac_pkg::t_chan pick_colour();
        case ($urandom_range(7))
            0:       return '0;
            1:       return rac_pkg::CHAN_MAX;
            default: return rac_pkg::t_chan'($urandom);
        endcase
    endfunction

    // Random pixel pair; alphas steered toward the interesting regions.
    function automatic t_pixel_pair random_pair();
        t_pixel_pair    p;
        rac_pkg::t_chan lo;
        p = '{pick_colour(), pick_colour(), pick_colour(), rac_pkg::t_chan'($urandom),
              pick_colour(), pick_colour(), pick_colour(), rac_pkg::t_chan'($urandom)};
        case ($urandom_range(9))
            0: begin
                // both alphas zero
                p.dst_alpha = '0;
                p.src_alpha = '0;
            end
            1, 2: begin
                // destination alpha under source alpha: the saturating region
                lo          = rac_pkg::t_chan'($urandom_range(254));
                p.dst_alpha = lo;
                p.src_alpha = rac_pkg::t_chan'($urandom_range(255, lo + 1));
            end
            3: p.dst_alpha = '0;
            4: p.src_alpha = '0;
            5: p.src_alpha = rac_pkg::CHAN_MAX;
            6: p.dst_alpha = rac_pkg::CHAN_MAX;
            default: ;
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corners: zero and full alphas, both alphas zero, saturation, bit patterns.
    task automatic test_directed_corners();
        t_pixel_pair corners[$];
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        corners.push_back(make_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        corners.push_back(make_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        corners.push_back(make_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        corners.push_back(make_pair(8'h12, 8'h80, 8'hFF, 8'h00, 8'hC3, 8'h00, 8'h7F, 8'hFF));
        corners.push_back(make_pair(8'h12, 8'h80, 8'hFF, 8'hFF, 8'hC3, 8'h00, 8'h7F, 8'h00));
        corners.push_back(make_pair(8'hFF, 8'hFF, 8'hFF, 8'd100, 8'hFF, 8'hFF, 8'hFF, 8'd200));
        corners.push_back(make_pair(8'hFF, 8'hF0, 8'hFF, 8'd127, 8'hFF, 8'hFF, 8'hE0, 8'd128));
        corners.push_back(make_pair(8'hFF, 8'hFF, 8'hFF, 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'd254));
        corners.push_back(make_pair(8'h00, 8'h00, 8'h00, 8'd128, 8'hFF, 8'hFF, 8'hFF, 8'd128));
        corners.push_back(make_pair(8'hFF, 8'h00, 8'hFF, 8'd0, 8'h00, 8'hFF, 8'h00, 8'd1));
        corners.push_back(make_pair(8'hFF, 8'h00, 8'hFF, 8'd1, 8'h00, 8'hFF, 8'h00, 8'd0));
        corners.push_back(make_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        corners.push_back(make_pair(8'h40, 8'h90, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'd1));
        corners.push_back(make_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55));
        corners.push_back(make_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA));
        corners.push_back(make_pair(8'h01, 8'h80, 8'hFE, 8'd254, 8'h7F, 8'h02, 8'hFD, 8'hFF));
        foreach (corners[i]) begin
            send_pixel(corners[i]);
        end
    endtask

    // Random pixels under a given idle mix on both sides.
    task automatic test_random_stream(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) begin
            send_pixel(random_pair());
        end
    endtask

    // Hold the receiver off for a long stretch while the sender keeps offering,
    // so the pipeline fills and the input stalls; then let it drain.
    task automatic test_backpressure_fill();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_len = 8 * rac_pkg::NST + 100;
        repeat (60) begin
            send_pixel(random_pair());
        end
    endtask

    // Send short bursts and hold the sender until each burst has fully returned.
    task automatic test_burst_and_drain();
        tx_idle_pct = 20;
        rx_idle_pct = 40;
        repeat (3) begin
            repeat (20) begin
                send_pixel(random_pair());
            end
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Drive every input known from time zero and hold reset before the tests start.
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.dst_red   = '0;
        in_ch.dst_green = '0;
        in_ch.dst_blue  = '0;
        in_ch.dst_alpha = '0;
        in_ch.src_red   = '0;
        in_ch.src_green = '0;
        in_ch.src_blue  = '0;
        in_ch.src_alpha = '0;
        out_ch.ready    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_random_stream(700, 31, 68);
        test_random_stream(700, 68, 31);
        test_random_stream(550, 0, 0);
        test_backpressure_fill();
        test_burst_and_drain();

        // Stop offering, let every result out, then watch a while for strays.
        rx_idle_pct = 0;
        drain_results();
        repeat (2 * rac_pkg::NST) @(posedge i_clk);

        $display("%0d pixels composited and checked: corners, saturation, zero alphas,",
                 n_received);
        $display("three idle mixes, a long output hold-off and burst-then-drain pauses");
        if (n_errors == 0 && pending_pixels.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
